// ===== design/tked_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tked_pkg
// shared types and constants of the terminal key escape decoder
// ----------------------------------------------------------------------------
package tked_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_ESC = 8'h1b;
	localparam logic [7:0] CH_FF  = 8'h0c;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CSI = 8'h5b;
	localparam logic [7:0] CH_K   = 8'h6b;
	localparam logic [7:0] CH_J   = 8'h6a;
	localparam logic [7:0] CH_H   = 8'h68;
	localparam logic [7:0] CH_L   = 8'h6c;
	localparam logic [7:0] CH_D   = 8'h64;
	localparam logic [7:0] CH_Q   = 8'h71;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UB  = 8'h42;
	localparam logic [7:0] CH_UC  = 8'h43;
	localparam logic [7:0] CH_UD  = 8'h44;

	typedef enum logic [2:0] {
		KEY_UP     = 3'd0,
		KEY_DOWN   = 3'd1,
		KEY_LEFT   = 3'd2,
		KEY_RIGHT  = 3'd3,
		KEY_SELECT = 3'd4,
		KEY_BACK   = 3'd5,
		KEY_DELETE = 3'd6,
		KEY_REDRAW = 3'd7
	} key_t;

	typedef enum logic [2:0] {
		ST_NORMAL = 3'b001,
		ST_ESC    = 3'b010,
		ST_CSI    = 3'b100
	} stage_t;

	typedef enum logic [1:0] {
		EOL_NONE = 2'd0,
		EOL_CR   = 2'd1,
		EOL_LF   = 2'd2
	} eol_t;

	typedef struct packed {
		logic [1:0] cnt;
		key_t       key0;
		key_t       key1;
	} result_t;

endpackage
`default_nettype wire

// ===== design/tked_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tked_decode
// escape stage and line-end tracking, maps one byte to up to two key events
// ----------------------------------------------------------------------------
module tked_decode
	import tked_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [7:0] byte_in,
	output result_t         result
);

	stage_t stage_q, stage_d;
	eol_t   pend_q, pend_d;

	logic   norm_hit;
	key_t   norm_key;
	stage_t norm_stage;
	eol_t   norm_pend;
	eol_t   kind;

	// byte as seen in normal stage
	always_comb begin
		norm_hit   = 1'b0;
		norm_key   = KEY_UP;
		norm_stage = ST_NORMAL;
		norm_pend  = EOL_NONE;
		kind       = (byte_in == CH_CR) ? EOL_CR : EOL_LF;
		if (byte_in == CH_CR || byte_in == CH_LF) begin
			if (pend_q != EOL_NONE && pend_q != kind) begin
				norm_pend = EOL_NONE;
			end else begin
				norm_hit  = 1'b1;
				norm_key  = KEY_SELECT;
				norm_pend = kind;
			end
		end else begin
			case (byte_in)
				CH_ESC: norm_stage = ST_ESC;
				CH_K: begin norm_hit = 1'b1; norm_key = KEY_UP; end
				CH_J: begin norm_hit = 1'b1; norm_key = KEY_DOWN; end
				CH_H: begin norm_hit = 1'b1; norm_key = KEY_LEFT; end
				CH_L: begin norm_hit = 1'b1; norm_key = KEY_RIGHT; end
				CH_D: begin norm_hit = 1'b1; norm_key = KEY_DELETE; end
				CH_Q: begin norm_hit = 1'b1; norm_key = KEY_BACK; end
				CH_FF: begin norm_hit = 1'b1; norm_key = KEY_REDRAW; end
				default: ;
			endcase
		end
	end

	always_comb begin
		result  = '{cnt: 2'd0, key0: KEY_UP, key1: KEY_UP};
		stage_d = ST_NORMAL;
		pend_d  = pend_q;
		unique case (stage_q)
			ST_ESC: begin
				if (byte_in == CH_CSI) begin
					stage_d = ST_CSI;
					pend_d  = EOL_NONE;
				end else begin
					result.cnt  = norm_hit ? 2'd2 : 2'd1;
					result.key0 = KEY_BACK;
					result.key1 = norm_key;
					stage_d     = norm_stage;
					pend_d      = norm_pend;
				end
			end
			ST_CSI: begin
				if (byte_in != CH_CR && byte_in != CH_LF) begin
					pend_d = EOL_NONE;
				end
				case (byte_in)
					CH_UA: begin result.cnt = 2'd1; result.key0 = KEY_UP; end
					CH_UB: begin result.cnt = 2'd1; result.key0 = KEY_DOWN; end
					CH_UC: begin result.cnt = 2'd1; result.key0 = KEY_RIGHT; end
					CH_UD: begin result.cnt = 2'd1; result.key0 = KEY_LEFT; end
					default: ;
				endcase
			end
			default: begin
				result.cnt  = {1'b0, norm_hit};
				result.key0 = norm_key;
				stage_d     = norm_stage;
				pend_d      = norm_pend;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_NORMAL;
			pend_q  <= EOL_NONE;
		end else if (adv) begin
			stage_q <= stage_d;
			pend_q  <= pend_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/tked_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tked_out_fifo
// small result queue, takes up to two events at once and sends one per word
// ----------------------------------------------------------------------------
module tked_out_fifo
	import tked_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire result_t          result,
	output logic                  room,
	output logic [CNT_W-1:0]      count,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output key_t                  out_key,
	output logic                  out_last
);

	key_t             key_q  [FIFO_DEPTH];
	logic             last_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [1:0]       n_push;

	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign count     = count_q;
	assign out_valid = count_q != '0;
	assign out_key   = key_q[rd_q];
	assign out_last  = last_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = push ? result.cnt : 2'd0;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			key_q[wr_q]  <= result.key0;
			last_q[wr_q] <= (n_push == 2'd1);
		end
		if (n_push == 2'd2) begin
			key_q[wr_q + PTR_W'(1)]  <= result.key1;
			last_q[wr_q + PTR_W'(1)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== design/terminal_key_escape_decoder.sv =====
// datapath: an accepted byte is held in the input register, decoded and written into the result queue
// throughput: one byte per cycle while the queue holds two events or fewer, else input waits
// the rate is set by the four-entry result queue draining one event per cycle while m_axis_tready is high
// reset: asynchronous active-low arst_n clears escape stage, line-end state and queue
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// terminal bytes in, key events out, with escape and line-end pair handling
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder
	import tked_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [2:0] key_event, [7:3] zero
	output logic            m_axis_tlast    // last_of_run
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;
	logic             room;
	logic [CNT_W-1:0] count;
	result_t          result;
	key_t             out_key;

	assign adv           = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tdata  = {5'b0, out_key};

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (s_axis_tvalid && s_axis_tready) || (valid_s1 && !adv);
		end
	end

	tked_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_in (byte_s1),
		.result  (result)
	);

	tked_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.result    (result),
		.room      (room),
		.count     (count),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_key   (out_key),
		.out_last  (m_axis_tlast)
	);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(FIFO_DEPTH))
		else $error("result queue over capacity");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("stalled input byte lost");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("second event of a byte missing");
`endif

endmodule
`default_nettype wire
